// ===== rtl/core/sdspi_pkg.sv =====
//------------------------------------------------------------------------------
// sdspi_pkg
// Shared types and constants for the SD SPI-mode host sequencer.
//------------------------------------------------------------------------------
`default_nettype none

package sdspi_pkg;

    localparam int BLOCK_BYTES  = 512;
    localparam int WARMUP_BYTES = 10;
    localparam int BUF_AW       = $clog2(BLOCK_BYTES);

    localparam logic [31:0] IF_COND_ARG = 32'h0000_01AA;
    localparam logic [31:0] HCS_ARG     = 32'h4000_0000;
    localparam logic [7:0]  CRC_CMD8    = 8'h87;
    localparam logic [7:0]  CRC_OTHER   = 8'h95;
    localparam logic [7:0]  START_TOKEN = 8'hFE;
    localparam logic [7:0]  DRESP_MASK  = 8'h1F;
    localparam logic [7:0]  DRESP_OK    = 8'h05;
    localparam logic [7:0]  OCR_CCS     = 8'h40;
    localparam logic [7:0]  R1_WAIT     = 8'h80;
    localparam logic [7:0]  FILL        = 8'hFF;

    // actions
    localparam logic [2:0] ACT_INIT  = 3'd0;
    localparam logic [2:0] ACT_READ  = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_XCHG  = 3'd3;
    localparam logic [2:0] ACT_BWR   = 3'd4;
    localparam logic [2:0] ACT_BRD   = 3'd5;

    // register indexes
    localparam logic [2:0] REG_IDLE_RETRY   = 3'd0;
    localparam logic [2:0] REG_OPCOND_RETRY = 3'd1;
    localparam logic [2:0] REG_RESP_POLL    = 3'd2;
    localparam logic [2:0] REG_TOKEN_POLL   = 3'd3;
    localparam logic [2:0] REG_BUSY_POLL    = 3'd4;

    // status codes
    localparam logic [3:0] STS_OK        = 4'd0;
    localparam logic [3:0] STS_NO_CARD   = 4'd1;
    localparam logic [3:0] STS_CMD0      = 4'd2;
    localparam logic [3:0] STS_CMD8_R1   = 4'd3;
    localparam logic [3:0] STS_CMD8_ECHO = 4'd4;
    localparam logic [3:0] STS_ACMD41    = 4'd5;
    localparam logic [3:0] STS_CMD58     = 4'd6;
    localparam logic [3:0] STS_CMD16     = 4'd7;
    localparam logic [3:0] STS_CSD       = 4'd8;
    localparam logic [3:0] STS_CMD_FAIL  = 4'd9;
    localparam logic [3:0] STS_TOKEN_TO  = 4'd10;
    localparam logic [3:0] STS_REJECT    = 4'd11;
    localparam logic [3:0] STS_BUSY_TO   = 4'd12;
    localparam logic [3:0] STS_WP        = 4'd13;

    typedef enum logic [3:0] {
        PH_IDLE, PH_WARM, PH_CMD, PH_POLL, PH_R3, PH_TAIL, PH_TOKEN,
        PH_RXDATA, PH_RXCRC, PH_TXDATA, PH_BUSY, PH_CSD
    } t_phase;

    typedef enum logic [3:0] {
        ST_CMD0, ST_CMD8, ST_CMD55, ST_ACMD41, ST_CMD58, ST_CMD16,
        ST_CSD, ST_CID, ST_READ, ST_WRITE
    } t_stage;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] block_address;
        logic [7:0]  rx_byte;
        logic [8:0]  buffer_index;
        logic [7:0]  buffer_data;
        logic        card_present;
        logic        write_protect_pin;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        exchange_request;
        logic        select_card;
        logic        busy_res;
        logic        done_res;
        logic [3:0]  status;
        logic [7:0]  buffer_out;
        logic [31:0] card_sectors;
        logic        uses_byte_address;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/sd_spi_host_sequencer_unit.sv =====
//------------------------------------------------------------------------------
// sd_spi_host_sequencer_unit
// SD card SPI-mode host engine: init, CSD decode, single-block read and write,
// one byte exchange per item, sector buffer held in a synchronous RAM.
//------------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  in        input      i_in_valid/o_in_ready  t_in_item
//  out       output     o_out_valid/i_out_ready t_out_item
//  cfg       input      i_cfg_we               i_cfg_index, i_cfg_data
//
//  An item that needs a buffer byte (buffer read, CMD8/CMD58 checks, write
//  data) waits on the registered read port of the sector buffer RAM before
//  it completes; other items complete when taken. After the last CSD CRC item
//  the engine reads bytes 0 and 5..10 from the buffer and decodes them.
//  Reset is synchronous, active low; the buffer RAM is not cleared.
//  A stalled output holds its result in the output register and no new item
//  is taken; input is held off while that register stays full, while a
//  buffer-read item waits on the RAM and during the CSD walk, and the CSD
//  result waits for a stalled output register to empty.
//------------------------------------------------------------------------------
`default_nettype none

module sd_spi_host_sequencer_unit (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_ready,
    input  sdspi_pkg::t_in_item     i_in_item,
    output logic                    o_out_valid,
    input  wire                     i_out_ready,
    output sdspi_pkg::t_out_item    o_out_item,
    input  wire                     i_cfg_we,
    input  wire  [2:0]              i_cfg_index,
    input  wire  [15:0]             i_cfg_data
);
    import sdspi_pkg::*;

    // configuration registers
    logic [7:0]  r_idle_lim, r_op_lim, r_resp_lim;
    logic [15:0] r_tok_lim, r_busy_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_lim <= 8'd10;
            r_op_lim   <= 8'd50;
            r_resp_lim <= 8'd100;
            r_tok_lim  <= 16'hFFFF;
            r_busy_lim <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IDLE_RETRY:   r_idle_lim <= i_cfg_data[7:0];
                REG_OPCOND_RETRY: r_op_lim   <= i_cfg_data[7:0];
                REG_RESP_POLL:    r_resp_lim <= i_cfg_data[7:0];
                REG_TOKEN_POLL:   r_tok_lim  <= i_cfg_data;
                REG_BUSY_POLL:    r_busy_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state
    t_phase      r_phase, n_phase;
    t_stage      r_stage, n_stage;
    logic [9:0]  r_bcnt, n_bcnt;
    logic [7:0]  r_retry, n_retry;
    logic [15:0] r_poll, n_poll;
    logic [47:0] r_cmd, n_cmd;
    logic [31:0] r_cached, n_cached;
    logic        r_cvalid, n_cvalid;
    logic        r_bam, n_bam;
    logic        r_prot, n_prot;
    logic        r_ready, n_ready;
    logic [31:0] r_sectors, n_sectors;
    logic [7:0]  r_last, n_last;
    logic [7:0]  r_ptx, n_ptx;
    logic        r_psel, n_psel;

    // item hold and buffer-read wait flow
    logic        r_wait, n_wait;         // buffer-read item waiting on the RAM read
    t_in_item    r_item, n_item;
    logic [3:0]  r_csd_step, n_csd_step;
    logic [7:0]  r_b0, r_b5, r_b6, r_b7, r_b8, r_b9;
    logic [7:0]  n_b0, n_b5, n_b6, n_b7, n_b8, n_b9;

    // sector buffer ram
    logic [7:0]        r_mem [BLOCK_BYTES];
    logic [7:0]        r_rdata;
    logic [BUF_AW-1:0] rd_addr, wr_addr;
    logic              rd_en, wr_en;
    logic [7:0]        wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    // output register
    t_out_item r_out, n_out;
    logic      r_ovalid, n_ovalid;

    logic take, busy_unit;
    assign busy_unit  = r_wait || (r_phase == PH_CSD);
    assign o_in_ready = !busy_unit && (!r_ovalid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // csd capacity decode helper
    function automatic logic [31:0] csd_sectors(input logic [7:0] b0, b5, b6, b7, b8, b9,
                                                input logic [7:0] b10);
        logic [2:0]  cm;
        logic [11:0] cs1;
        logic [21:0] cs2;
        logic [3:0]  bl;
        logic [31:0] s;
        cm  = {b9[1:0], b10[7]};
        cs1 = {b6[1:0], b7, b8[7:6]};
        cs2 = {b7[5:0], b8, b9};
        bl  = b5[3:0];
        s   = 32'd0;
        if (b0[7:6] == 2'd0) begin
            s = ({20'd0, cs1} + 32'd1) << ({29'd0, cm} + 32'd2);
            if (bl < 4'd9) s = 32'd0;
            else s = s << (bl - 4'd9);
        end else if (b0[7:6] == 2'd1) begin
            if (cs2 == 22'h3FFFFF) s = 32'hFFFF_FFFF;
            else s = ({10'd0, cs2} + 32'd1) << 10;
        end
        return s;
    endfunction

    // main next-state logic
    t_in_item  it;
    logic      proc;       // item completes this cycle
    logic [7:0] bufb;      // buffer byte available this cycle
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [5:0]  cidx;

    always_comb begin
        n_phase = r_phase; n_stage = r_stage; n_bcnt = r_bcnt; n_retry = r_retry;
        n_poll = r_poll; n_cmd = r_cmd; n_cached = r_cached; n_cvalid = r_cvalid;
        n_bam = r_bam; n_prot = r_prot; n_ready = r_ready; n_sectors = r_sectors;
        n_last = r_last; n_ptx = r_ptx; n_psel = r_psel;
        n_wait = 1'b0; n_item = r_item; n_csd_step = r_csd_step;
        n_b0 = r_b0; n_b5 = r_b5; n_b6 = r_b6; n_b7 = r_b7; n_b8 = r_b8; n_b9 = r_b9;
        n_out = r_out;
        n_ovalid = r_ovalid && !i_out_ready;
        rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
        arg = '0; crc = CRC_OTHER; cidx = '0;
        bufb = r_rdata;
        proc = 1'b0;
        it = r_wait ? r_item : i_in_item;

        // csd walk: read bytes 0,5..10 one per cycle
        if (r_phase == PH_CSD) begin
            rd_en = 1'b1;
            case (r_csd_step)
                4'd0: rd_addr = BUF_AW'(5);
                4'd1: rd_addr = BUF_AW'(6);
                4'd2: rd_addr = BUF_AW'(7);
                4'd3: rd_addr = BUF_AW'(8);
                4'd4: rd_addr = BUF_AW'(9);
                4'd5, 4'd6: rd_addr = BUF_AW'(10);
                default: rd_addr = '0;
            endcase
            n_csd_step = r_csd_step + 4'd1;
            case (r_csd_step)
                4'd1: n_b5 = r_rdata;
                4'd2: n_b6 = r_rdata;
                4'd3: n_b7 = r_rdata;
                4'd4: n_b8 = r_rdata;
                4'd5: n_b9 = r_rdata;
                default: ;
            endcase
            if (r_csd_step == 4'd0) n_b0 = r_rdata;
            if (r_csd_step == 4'd6 && r_ovalid && !i_out_ready) begin
                // previous result still waiting, hold the decode
                n_csd_step = r_csd_step;
            end else if (r_csd_step == 4'd6) begin
                n_sectors = csd_sectors(r_b0, r_b5, r_b6, r_b7, r_b8, r_b9, r_rdata);
                n_out = '0;
                n_ovalid = 1'b1;
                if (n_sectors == 32'd0) begin
                    n_sectors = r_sectors;
                    n_phase = PH_IDLE; n_ptx = '0; n_psel = 1'b0;
                    n_out.done_res = 1'b1; n_out.status = STS_CSD;
                end else begin
                    n_stage = ST_CID;
                    n_cmd = {8'h4A, 32'd0, CRC_OTHER};
                    n_phase = PH_CMD; n_bcnt = '0;
                    n_ptx = 8'h4A; n_psel = 1'b1;
                    n_out.tx_byte = 8'h4A; n_out.exchange_request = 1'b1;
                    n_out.select_card = 1'b1; n_out.busy_res = 1'b1;
                end
                n_out.card_sectors = n_sectors;
                n_out.uses_byte_address = r_bam;
            end
        end else if (take || r_wait) begin
            // first cycle: does this item need a buffer byte
            if (!r_wait && take) begin
                n_item = i_in_item;
                if (r_phase == PH_IDLE && i_in_item.action == ACT_BRD) begin
                    rd_en = 1'b1; rd_addr = i_in_item.buffer_index[BUF_AW-1:0]; n_wait = 1'b1;
                end else if (r_phase == PH_TAIL && i_in_item.action == ACT_XCHG &&
                             r_stage == ST_CMD8) begin
                    rd_en = 1'b1; rd_addr = BUF_AW'(4); n_wait = 1'b1;
                end else if (r_phase == PH_TAIL && i_in_item.action == ACT_XCHG &&
                             r_stage == ST_CMD58) begin
                    rd_en = 1'b1; rd_addr = BUF_AW'(1); n_wait = 1'b1;
                end else if (r_phase == PH_TXDATA && i_in_item.action == ACT_XCHG &&
                             r_bcnt < 10'(BLOCK_BYTES)) begin
                    rd_en = 1'b1; rd_addr = r_bcnt[BUF_AW-1:0]; n_wait = 1'b1;
                end
            end
            proc = !n_wait;
        end

        if (proc) begin
            n_out = '0;
            n_ovalid = 1'b1;
            if (r_phase != PH_IDLE) begin
                n_out.tx_byte = r_ptx; n_out.exchange_request = 1'b1;
                n_out.select_card = r_psel; n_out.busy_res = 1'b1;
                if (it.action == ACT_XCHG) begin
                    // defaults for a plain 0xFF poll byte
                    n_ptx = FILL; n_psel = 1'b1;
                    unique case (r_phase)
                        PH_WARM: begin
                            n_bcnt = r_bcnt + 10'd1;
                            n_psel = 1'b0;
                            if (n_bcnt >= 10'(WARMUP_BYTES)) begin
                                n_prot = it.write_protect_pin; n_retry = '0;
                                n_stage = ST_CMD0; cidx = 6'd0; n_phase = PH_CMD;
                            end
                        end
                        PH_CMD: begin
                            n_bcnt = r_bcnt + 10'd1;
                            if (n_bcnt < 10'd6) n_ptx = r_cmd[47 - 8*n_bcnt[2:0] -: 8];
                            else begin n_phase = PH_POLL; n_poll = '0; end
                        end
                        PH_POLL, PH_R3: begin
                            if (r_phase == PH_R3) begin
                                wr_en = 1'b1; wr_addr = r_bcnt[BUF_AW-1:0]; wr_data = it.rx_byte;
                                // echo byte 3 parks in r_b0 until the tail check
                                if (r_bcnt == 10'd3) n_b0 = it.rx_byte;
                                n_bcnt = r_bcnt + 10'd1;
                                if (n_bcnt >= 10'd5) n_phase = PH_TAIL;
                            end else if ((it.rx_byte & R1_WAIT) == 8'd0 ||
                                         {8'd0, r_poll[7:0]} >= {8'd0, r_resp_lim} &&
                                         r_poll[15:8] == 8'd0 || r_poll[15:8] != 8'd0) begin
                                n_last = ((it.rx_byte & R1_WAIT) == 8'd0) ? it.rx_byte : FILL;
                                if (r_stage == ST_CMD8 || r_stage == ST_CMD58) begin
                                    wr_en = 1'b1; wr_addr = '0; wr_data = n_last;
                                    n_bcnt = 10'd1; n_phase = PH_R3;
                                end else if (r_stage == ST_CMD0 || r_stage == ST_CMD55 ||
                                             r_stage == ST_ACMD41 || r_stage == ST_CMD16) begin
                                    n_phase = PH_TAIL;
                                end else if (n_last != 8'd0) begin
                                    n_phase = PH_IDLE;
                                    n_out.status = (r_stage == ST_READ || r_stage == ST_WRITE) ?
                                                   STS_CMD_FAIL : STS_CSD;
                                end else if (r_stage == ST_WRITE) begin
                                    n_phase = PH_TXDATA; n_bcnt = '0; n_ptx = START_TOKEN;
                                end else begin
                                    n_phase = PH_TOKEN; n_poll = '0;
                                end
                            end else n_poll = r_poll + 16'd1;
                        end
                        PH_TAIL: begin
                            unique case (r_stage)
                                ST_CMD0: begin
                                    if (r_last == 8'd1) begin n_stage = ST_CMD8; n_phase = PH_CMD; end
                                    else if (r_retry < r_idle_lim) begin
                                        n_retry = r_retry + 8'd1; n_phase = PH_CMD;
                                    end else begin n_phase = PH_IDLE; n_out.status = STS_CMD0; end
                                end
                                ST_CMD8: begin
                                    if (r_last != 8'd1) begin n_phase = PH_IDLE; n_out.status = STS_CMD8_R1; end
                                    else if (r_b0 != 8'h01 || bufb != 8'hAA) begin
                                        n_phase = PH_IDLE; n_out.status = STS_CMD8_ECHO;
                                    end else begin n_retry = '0; n_stage = ST_CMD55; n_phase = PH_CMD; end
                                end
                                ST_CMD55: begin n_stage = ST_ACMD41; n_phase = PH_CMD; end
                                ST_ACMD41: begin
                                    if (r_last == 8'd0) begin n_stage = ST_CMD58; n_phase = PH_CMD; end
                                    else if (r_retry < r_op_lim) begin
                                        n_retry = r_retry + 8'd1; n_stage = ST_CMD55; n_phase = PH_CMD;
                                    end else begin n_phase = PH_IDLE; n_out.status = STS_ACMD41; end
                                end
                                ST_CMD58: begin
                                    if (r_last != 8'd0) begin n_phase = PH_IDLE; n_out.status = STS_CMD58; end
                                    else begin
                                        n_bam = (bufb & OCR_CCS) == 8'd0;
                                        n_stage = ST_CMD16; n_phase = PH_CMD;
                                    end
                                end
                                ST_CMD16: begin
                                    if (r_last != 8'd0) begin n_phase = PH_IDLE; n_out.status = STS_CMD16; end
                                    else begin n_stage = ST_CSD; n_phase = PH_CMD; end
                                end
                                default: begin n_phase = PH_IDLE; n_out.status = STS_CSD; end
                            endcase
                        end
                        PH_TOKEN: begin
                            if (it.rx_byte == START_TOKEN) begin n_phase = PH_RXDATA; n_bcnt = '0; end
                            else if (r_poll >= r_tok_lim) begin
                                n_phase = PH_IDLE;
                                n_out.status = (r_stage == ST_READ) ? STS_TOKEN_TO : STS_CSD;
                            end else n_poll = r_poll + 16'd1;
                        end
                        PH_RXDATA: begin
                            wr_en = 1'b1; wr_addr = r_bcnt[BUF_AW-1:0]; wr_data = it.rx_byte;
                            n_bcnt = r_bcnt + 10'd1;
                            if (n_bcnt >= ((r_stage == ST_READ) ? 10'(BLOCK_BYTES) : 10'd16)) begin
                                n_phase = PH_RXCRC; n_bcnt = '0;
                            end
                        end
                        PH_RXCRC: begin
                            n_bcnt = r_bcnt + 10'd1;
                            if (n_bcnt >= 10'd3) begin
                                if (r_stage == ST_CSD) begin
                                    // hand off to the buffer walk, no result this cycle
                                    n_phase = PH_CSD; n_csd_step = '0;
                                    rd_en = 1'b1; rd_addr = '0;
                                    n_ovalid = r_ovalid && !i_out_ready;
                                    n_out = r_out;
                                end else begin
                                    if (r_stage == ST_CID) n_ready = 1'b1;
                                    else n_cvalid = 1'b1;
                                    n_phase = PH_IDLE; n_out.status = STS_OK;
                                end
                            end
                        end
                        PH_TXDATA: begin
                            if (r_bcnt >= 10'(BLOCK_BYTES + 3)) begin
                                if ((it.rx_byte & DRESP_MASK) != DRESP_OK) begin
                                    n_phase = PH_IDLE; n_out.status = STS_REJECT;
                                end else begin n_phase = PH_BUSY; n_poll = '0; end
                            end else begin
                                n_bcnt = r_bcnt + 10'd1;
                                if (r_bcnt < 10'(BLOCK_BYTES)) n_ptx = bufb;
                            end
                        end
                        PH_BUSY: begin
                            if (it.rx_byte != 8'd0) begin n_phase = PH_IDLE; n_out.status = STS_OK; end
                            else if (r_poll >= r_busy_lim) begin
                                n_phase = PH_IDLE; n_out.status = STS_BUSY_TO;
                            end else n_poll = r_poll + 16'd1;
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                    // command setup for a new stage or retry
                    if (n_phase == PH_CMD && (r_phase == PH_WARM || r_phase == PH_TAIL)) begin
                        unique case (n_stage)
                            ST_CMD0:   begin cidx = 6'd0;  arg = '0; end
                            ST_CMD8:   begin cidx = 6'd8;  arg = IF_COND_ARG; crc = CRC_CMD8; end
                            ST_CMD55:  begin cidx = 6'd55; arg = '0; end
                            ST_ACMD41: begin cidx = 6'd41; arg = HCS_ARG; end
                            ST_CMD58:  begin cidx = 6'd58; arg = '0; end
                            ST_CMD16:  begin cidx = 6'd16; arg = 32'(BLOCK_BYTES); end
                            default:   begin cidx = 6'd9;  arg = '0; end
                        endcase
                        n_cmd = {2'b01, cidx, arg, crc};
                        n_bcnt = '0; n_ptx = {2'b01, cidx}; n_psel = 1'b1;
                    end
                    if (n_phase == PH_IDLE) begin
                        n_ptx = '0; n_psel = 1'b0;
                        if (r_stage == ST_READ && n_out.status != STS_OK) begin
                            n_cached = 32'hFFFF_FFFF; n_cvalid = 1'b0;
                        end
                        n_out.exchange_request = 1'b0; n_out.tx_byte = '0;
                        n_out.select_card = 1'b0; n_out.busy_res = 1'b0;
                        n_out.done_res = 1'b1;
                    end else if (n_phase != PH_CSD) begin
                        n_out.tx_byte = n_ptx; n_out.select_card = n_psel;
                    end
                end
            end else begin
                // idle: start operations and buffer access
                unique case (it.action)
                    ACT_INIT: begin
                        n_ready = 1'b0; n_cvalid = 1'b0; n_cached = 32'hFFFF_FFFF;
                        n_stage = ST_CMD0;
                        if (!it.card_present) begin
                            n_out.done_res = 1'b1; n_out.status = STS_NO_CARD;
                        end else begin
                            n_phase = PH_WARM; n_bcnt = '0; n_ptx = FILL; n_psel = 1'b0;
                            n_out.tx_byte = FILL; n_out.exchange_request = 1'b1;
                            n_out.busy_res = 1'b1;
                        end
                    end
                    ACT_READ, ACT_WRITE: begin
                        n_stage = (it.action == ACT_READ) ? ST_READ : ST_WRITE;
                        arg = r_bam ? {it.block_address[31-BUF_AW:0], {BUF_AW{1'b0}}}
                                    : it.block_address;
                        cidx = (it.action == ACT_READ) ? 6'd17 : 6'd24;
                        if (!r_ready) begin
                            n_out.done_res = 1'b1; n_out.status = STS_CMD_FAIL;
                            if (it.action == ACT_READ) begin
                                n_cached = 32'hFFFF_FFFF; n_cvalid = 1'b0;
                            end
                        end else if (it.action == ACT_READ && r_cvalid &&
                                     r_cached == it.block_address) begin
                            n_out.done_res = 1'b1; n_out.status = STS_OK;
                        end else if (it.action == ACT_WRITE && r_prot) begin
                            n_out.done_res = 1'b1; n_out.status = STS_WP;
                        end else begin
                            if (it.action == ACT_READ) begin
                                n_cached = it.block_address; n_cvalid = 1'b0;
                            end
                            n_cmd = {2'b01, cidx, arg, CRC_OTHER};
                            n_phase = PH_CMD; n_bcnt = '0;
                            n_ptx = {2'b01, cidx}; n_psel = 1'b1;
                            n_out.tx_byte = {2'b01, cidx}; n_out.exchange_request = 1'b1;
                            n_out.select_card = 1'b1; n_out.busy_res = 1'b1;
                        end
                    end
                    ACT_BWR: begin
                        wr_en = 1'b1; wr_addr = it.buffer_index[BUF_AW-1:0];
                        wr_data = it.buffer_data;
                    end
                    ACT_BRD: n_out.buffer_out = bufb;
                    default: ;
                endcase
            end
            n_out.card_sectors = n_sectors;
            n_out.uses_byte_address = n_bam;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_stage <= ST_CMD0; r_bcnt <= '0; r_retry <= '0;
            r_poll <= '0; r_cmd <= '0; r_cached <= 32'hFFFF_FFFF; r_cvalid <= 1'b0;
            r_bam <= 1'b0; r_prot <= 1'b0; r_ready <= 1'b0; r_sectors <= '0;
            r_last <= '0; r_ptx <= '0; r_psel <= 1'b0; r_wait <= 1'b0;
            r_csd_step <= '0; r_ovalid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_stage <= n_stage; r_bcnt <= n_bcnt; r_retry <= n_retry;
            r_poll <= n_poll; r_cmd <= n_cmd; r_cached <= n_cached; r_cvalid <= n_cvalid;
            r_bam <= n_bam; r_prot <= n_prot; r_ready <= n_ready; r_sectors <= n_sectors;
            r_last <= n_last; r_ptx <= n_ptx; r_psel <= n_psel; r_wait <= n_wait;
            r_csd_step <= n_csd_step; r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item; r_out <= n_out;
        r_b0 <= n_b0; r_b5 <= n_b5; r_b6 <= n_b6; r_b7 <= n_b7; r_b8 <= n_b8; r_b9 <= n_b9;
    end

    // checks
    a_no_take_while_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> !o_in_ready) else $error("input taken during buffer read wait");
    a_wait_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |=> !r_wait) else $error("buffer read wait longer than one cycle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> r_ovalid) else $error("result dropped under stall");
    a_idle_no_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> !r_psel) else $error("select held while idle");

endmodule

`default_nettype wire
